### rtl/polygon_area_centroid_core_defines.svh
// assertion macros shared by the polygon area and centroid rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef POLYGON_AREA_CENTROID_CORE_DEFINES_SVH
`define POLYGON_AREA_CENTROID_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PAC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polygon area centroid assertion failed");

// antecedent implies consequent in the next cycle
`define PAC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polygon area centroid assertion failed");

`endif

### rtl/pac_pkg.sv
// shared types and constants for the polygon area and centroid block
// no dependencies
package pac_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_W = 16;
    localparam int AREA_W  = 40;
    localparam int MOM_W   = 58;
    localparam int DAREA_W = 38;
    localparam int DIVN_W  = 60;
    localparam int DIVD_W  = 43;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_DEGEN = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    // one finished ring, handed from front to back
    typedef struct packed {
        status_t                   status;
        logic signed [AREA_W-1:0]  area;
        logic signed [MOM_W-1:0]   mom_x;
        logic signed [MOM_W-1:0]   mom_y;
    } ring_rec_t;

endpackage

### rtl/pac_vertex_if.sv
// vertex request channel: valid, ready and one vertex
// uses pac_pkg
interface pac_vertex_if
    import pac_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

### rtl/pac_result_if.sv
// result request channel: valid, ready and one ring result
// uses pac_pkg
interface pac_result_if
    import pac_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [DAREA_W-1:0]        double_area;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic                      was_clockwise;
    logic [1:0]                status;

    modport source (output valid, output double_area, output centroid_x,
                    output centroid_y, output was_clockwise, output status, input ready);
    modport sink (input valid, input double_area, input centroid_x,
                  input centroid_y, input was_clockwise, input status, output ready);
endinterface

### rtl/pac_front.sv
// front end: takes vertices, runs the shoelace edge sequence, builds ring records
// uses pac_pkg, pac_vertex_if and the assertion macros
`include "polygon_area_centroid_core_defines.svh"

module pac_front
    import pac_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pac_vertex_if.sink vin,
    output ring_rec_t  rec,
    output logic       push,
    input  logic       q_full
);
    localparam int CNT_W = $clog2(MAX_VERTICES + 2);
    localparam logic [CNT_W-1:0] MAXV  = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] OVERV = CNT_W'(MAX_VERTICES + 1);
    localparam logic [CNT_W-1:0] MINV  = CNT_W'(3);
    localparam logic [CNT_W-1:0] ONEV  = CNT_W'(1);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CROSS, S_MOM, S_ACC, S_PUSH} state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      last_reg;
    logic                      close_reg;
    status_t                   pre_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [2*COORD_W-1:0] p1_reg, p2_reg;
    logic signed [COORD_W:0]   sx_reg, sy_reg;
    logic signed [2*COORD_W:0] c_reg;
    logic signed [3*COORD_W+1:0] mx_reg, my_reg;
    logic signed [AREA_W-1:0]  area_sum_reg;
    logic signed [MOM_W-1:0]   cx_sum_reg, cy_sum_reg;

    assign vin.ready = (state_reg == S_IDLE);
    assign push      = (state_reg == S_PUSH) && !q_full;
    assign rec       = '{status: pre_reg, area: area_sum_reg,
                         mom_x: cx_sum_reg, mom_y: cy_sum_reg};

    // edge sequencer and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            last_reg     <= 1'b0;
            close_reg    <= 1'b0;
            pre_reg      <= ST_OK;
            area_sum_reg <= '0;
            cx_sum_reg   <= '0;
            cy_sum_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (vin.valid)
                    begin
                        last_reg <= vin.last_vertex;
                        if (count_reg >= MAXV)
                        begin
                            count_reg <= OVERV;
                            pre_reg   <= ST_LONG;
                            state_reg <= vin.last_vertex ? S_PUSH : S_IDLE;
                        end
                        else if (count_reg == '0)
                        begin
                            first_x_reg <= vin.vertex_x;
                            first_y_reg <= vin.vertex_y;
                            prev_x_reg  <= vin.vertex_x;
                            prev_y_reg  <= vin.vertex_y;
                            count_reg   <= ONEV;
                            pre_reg     <= ST_SHORT;
                            state_reg   <= vin.last_vertex ? S_PUSH : S_IDLE;
                        end
                        else
                        begin
                            xa_reg     <= prev_x_reg;
                            ya_reg     <= prev_y_reg;
                            xb_reg     <= vin.vertex_x;
                            yb_reg     <= vin.vertex_y;
                            prev_x_reg <= vin.vertex_x;
                            prev_y_reg <= vin.vertex_y;
                            count_reg  <= count_reg + ONEV;
                            pre_reg    <= ((count_reg + ONEV) < MINV) ? ST_SHORT : ST_OK;
                            close_reg  <= vin.last_vertex && ((count_reg + ONEV) >= MINV);
                            state_reg  <= S_MUL;
                        end
                    end
                end
                // the two cross terms and coordinate sums
                S_MUL:
                begin
                    p1_reg    <= xa_reg * yb_reg;
                    p2_reg    <= xb_reg * ya_reg;
                    sx_reg    <= (COORD_W+1)'(xa_reg) + (COORD_W+1)'(xb_reg);
                    sy_reg    <= (COORD_W+1)'(ya_reg) + (COORD_W+1)'(yb_reg);
                    state_reg <= S_CROSS;
                end
                S_CROSS:
                begin
                    c_reg     <= (2*COORD_W+1)'(p1_reg) - (2*COORD_W+1)'(p2_reg);
                    state_reg <= S_MOM;
                end
                // centroid moment products, area accumulate
                S_MOM:
                begin
                    mx_reg       <= sx_reg * c_reg;
                    my_reg       <= sy_reg * c_reg;
                    area_sum_reg <= area_sum_reg + AREA_W'(c_reg);
                    state_reg    <= S_ACC;
                end
                S_ACC:
                begin
                    cx_sum_reg <= cx_sum_reg + MOM_W'(mx_reg);
                    cy_sum_reg <= cy_sum_reg + MOM_W'(my_reg);
                    if (close_reg)
                    begin
                        // closing edge back to the first vertex
                        xa_reg    <= prev_x_reg;
                        ya_reg    <= prev_y_reg;
                        xb_reg    <= first_x_reg;
                        yb_reg    <= first_y_reg;
                        close_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= last_reg ? S_PUSH : S_IDLE;
                    end
                end
                S_PUSH:
                begin
                    if (!q_full)
                    begin
                        count_reg    <= '0;
                        area_sum_reg <= '0;
                        cx_sum_reg   <= '0;
                        cy_sum_reg   <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PAC_ASSERT_IMP(a_push_room, push, !q_full)
    `PAC_ASSERT_NXT(a_edge_busy, vin.valid && vin.ready && count_reg != '0 && count_reg < MAXV,
                    !vin.ready)
    `PAC_ASSERT_NXT(a_clear_after_push, push, count_reg == '0 && area_sum_reg == '0)

endmodule

### rtl/pac_queue.sv
// two-entry queue of ring records between front and back
// uses pac_pkg
module pac_queue
    import pac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ring_rec_t wdata,
    output logic      full,
    input  logic      pop,
    output ring_rec_t rdata,
    output logic      empty
);
    ring_rec_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/pac_div.sv
// restoring divider, one quotient bit per cycle
// uses pac_pkg for default widths
module pac_div
    import pac_pkg::*;
#(
    parameter int NW = DIVN_W,
    parameter int DW = DIVD_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);
    localparam logic [CW-1:0] LASTC = CW'(NW - 1);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] den_reg, rem_reg;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {rem_reg, q_reg[NW-1]};
    assign fits   = (rem_sh >= {1'b0, den_reg});
    assign done   = done_reg;
    assign quot   = q_reg;

    // shift, trial subtract, shift in quotient bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                q_reg    <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == LASTC)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/pac_back.sv
// back end: status checks, centroid division, result register
// uses pac_pkg, pac_result_if and pac_div
module pac_back
    import pac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ring_rec_t           rec,
    input  logic                q_empty,
    output logic                pop,
    input  logic [15:0]         area_epsilon,
    pac_result_if.source        rout
);
    typedef enum logic [2:0] {B_IDLE, B_EVAL, B_DIVX, B_DIVY, B_OUT} state_t;

    state_t                    state_reg;
    status_t                   pre_reg;
    logic [AREA_W-1:0]         mag_reg;
    logic [MOM_W-1:0]          nx_reg, ny_reg;
    logic                      cw_reg, negx_reg, negy_reg;
    logic [DIVN_W-1:0]         numy_reg, div_num_reg;
    logic [DIVD_W-1:0]         div_den_reg;
    logic                      div_start_reg;
    logic [DIVN_W-1:0]         qx_reg, quot;
    logic                      div_done;
    logic [DAREA_W-1:0]        darea_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic                      ocw_reg;
    status_t                   ost_reg;
    logic [DIVD_W-2:0]         d3;

    // rounded quotient to signed coordinate with saturation
    function automatic logic [COORD_W-1:0] sat_coord(input logic [DIVN_W-1:0] q,
                                                      input logic neg);
        logic [COORD_W-1:0] r;
        if (neg)
        begin
            r = (q > DIVN_W'(32768)) ? 16'h8000 : COORD_W'(-q);
        end
        else
        begin
            r = (q > DIVN_W'(32767)) ? 16'h7fff : q[COORD_W-1:0];
        end
        return r;
    endfunction

    assign pop  = (state_reg == B_IDLE) && !q_empty;
    assign d3   = (DIVD_W-1)'({mag_reg, 1'b0}) + (DIVD_W-1)'(mag_reg);

    assign rout.valid         = (state_reg == B_OUT);
    assign rout.double_area   = darea_reg;
    assign rout.centroid_x    = cx_reg;
    assign rout.centroid_y    = cy_reg;
    assign rout.was_clockwise = ocw_reg;
    assign rout.status        = ost_reg;

    pac_div #(
        .NW (DIVN_W),
        .DW (DIVD_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // ring evaluation sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        pre_reg   <= rec.status;
                        mag_reg   <= rec.area[AREA_W-1] ? AREA_W'(-rec.area) : rec.area;
                        nx_reg    <= rec.mom_x[MOM_W-1] ? MOM_W'(-rec.mom_x) : rec.mom_x;
                        ny_reg    <= rec.mom_y[MOM_W-1] ? MOM_W'(-rec.mom_y) : rec.mom_y;
                        cw_reg    <= rec.area[AREA_W-1];
                        negx_reg  <= rec.mom_x[MOM_W-1] != rec.area[AREA_W-1];
                        negy_reg  <= rec.mom_y[MOM_W-1] != rec.area[AREA_W-1];
                        state_reg <= B_EVAL;
                    end
                end
                B_EVAL:
                begin
                    darea_reg <= '0;
                    cx_reg    <= '0;
                    cy_reg    <= '0;
                    ocw_reg   <= 1'b0;
                    if (pre_reg != ST_OK)
                    begin
                        ost_reg   <= pre_reg;
                        state_reg <= B_OUT;
                    end
                    else if (mag_reg <= AREA_W'(area_epsilon))
                    begin
                        ost_reg   <= ST_DEGEN;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        div_num_reg   <= DIVN_W'({nx_reg, 1'b0}) + DIVN_W'(d3);
                        numy_reg      <= DIVN_W'({ny_reg, 1'b0}) + DIVN_W'(d3);
                        div_den_reg   <= {d3, 1'b0};
                        div_start_reg <= 1'b1;
                        state_reg     <= B_DIVX;
                    end
                end
                B_DIVX:
                begin
                    if (div_done)
                    begin
                        qx_reg        <= quot;
                        div_num_reg   <= numy_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= B_DIVY;
                    end
                end
                B_DIVY:
                begin
                    if (div_done)
                    begin
                        darea_reg <= mag_reg[DAREA_W-1:0];
                        cx_reg    <= sat_coord(qx_reg, negx_reg);
                        cy_reg    <= sat_coord(quot, negy_reg);
                        ocw_reg   <= cw_reg;
                        ost_reg   <= ST_OK;
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (rout.ready)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/polygon_area_centroid_core.sv
// Shoelace area and centroid of one polygon ring per stream of vertices. The front
// end takes one vertex when ready: the first vertex of a ring is only stored, every
// other vertex up to MAX_VERTICES is accepted and runs four steps of the shared edge
// multiplier sequence, and the last runs those steps again for the closing edge
// before the ring is handed on. Finished rings wait in a two-entry queue; the back
// end runs two bit-serial divider passes on a valid ring and none on a short,
// overlong or degenerate one, then holds the result until it is taken. The front
// holds a finished ring only when two rings are already queued. The user must write
// area_epsilon via cfg_wr_en/cfg_wr_data while the block is idle; not enforced.
// depends on pac_pkg, both channel interfaces, pac_front, pac_queue and pac_back
module polygon_area_centroid_core
    import pac_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pac_vertex_if.sink   vertex,
    pac_result_if.source result,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);
    logic [15:0] epsilon_reg;
    ring_rec_t   push_rec, pop_rec;
    logic        push, pop, q_full, q_empty;

    // degenerate-area threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            epsilon_reg <= cfg_wr_data;
        end
    end

    pac_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .vin    (vertex),
        .rec    (push_rec),
        .push   (push),
        .q_full (q_full)
    );

    pac_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_rec),
        .full  (q_full),
        .pop   (pop),
        .rdata (pop_rec),
        .empty (q_empty)
    );

    pac_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec          (pop_rec),
        .q_empty      (q_empty),
        .pop          (pop),
        .area_epsilon (epsilon_reg),
        .rout         (result)
    );

endmodule

### verif/polygon_area_centroid_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the polygon area and centroid core
// depends on pac_pkg, pac_vertex_if, pac_result_if and polygon_area_centroid_core
module polygon_area_centroid_core_tb;
    import pac_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } vertex_t;

    typedef struct {
        logic [37:0]        darea;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic               cw;
        status_t            st;
    } ring_res_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [15:0] cfg_wr_data;

    pac_vertex_if vertex ();
    pac_result_if result ();

    polygon_area_centroid_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .vertex(vertex.sink),
        .result(result.source),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // predictor state
    logic [15:0] eps;
    longint fx, fy, px, py, asum, mx, my;
    int vcount;

    vertex_t   pending_vertices[$];
    ring_res_t expected_rings[$];

    int idle_pct;
    int stall_pct;
    int errors;
    int mismatches;
    int rings_seen;
    int vertices_sent;
    longint cycles;
    logic vtx_taken;

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void ring_clear();
        fx = 0; fy = 0; px = 0; py = 0;
        asum = 0; mx = 0; my = 0; vcount = 0;
    endfunction

    function automatic void edge_add(longint xa, longint ya, longint xb, longint yb);
        longint c;
        c = xa * yb - xb * ya;
        asum += c;
        mx += (xa + xb) * c;
        my += (ya + yb) * c;
    endfunction

    // numerator over three times twice-area, rounded half away, saturated
    function automatic logic signed [15:0] centroid_of(longint num, longint twice);
        logic [63:0] n, a, d, q;
        logic neg;
        neg = (num < 0) != (twice < 0);
        n = num < 0 ? -num : num;
        a = twice < 0 ? -twice : twice;
        d = 3 * a;
        q = (2 * n + d) / (2 * d);
        if (num == 0)
            q = 0;
        if (neg)
            return q > 32768 ? -16'sd32768 : -$signed(q[15:0]);
        else
            return q > 32767 ? 16'sd32767 : $signed(q[15:0]);
    endfunction

    // ring accumulation; queues the expected result on the last vertex
    function automatic void predict_vertex(vertex_t v);
        ring_res_t r;
        longint mag;
        if (vcount >= MAX_VERTICES_DEF)
            vcount = MAX_VERTICES_DEF + 1;
        else
        begin
            if (vcount == 0)
            begin
                fx = v.x;
                fy = v.y;
            end
            else
                edge_add(px, py, v.x, v.y);
            px = v.x;
            py = v.y;
            vcount++;
        end
        if (!v.last)
            return;
        r.darea = '0; r.cx = '0; r.cy = '0; r.cw = 1'b0;
        if (vcount > MAX_VERTICES_DEF)
            r.st = ST_LONG;
        else if (vcount < 3)
            r.st = ST_SHORT;
        else
        begin
            edge_add(px, py, fx, fy);
            mag = asum < 0 ? -asum : asum;
            if (mag <= longint'(eps))
                r.st = ST_DEGEN;
            else
            begin
                r.st = ST_OK;
                r.darea = mag[37:0];
                r.cx = centroid_of(mx, asum);
                r.cy = centroid_of(my, asum);
                r.cw = asum < 0;
            end
        end
        expected_rings = {expected_rings, r};
        ring_clear();
    endfunction

    // driver: one request per handshake, inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!vertex.valid || vtx_taken)
            begin
                vtx_taken = 1'b0;
                if (pending_vertices.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    vertex_t v;
                    v = pending_vertices.pop_front();
                    vertex.valid <= 1'b1;
                    vertex.vertex_x <= v.x;
                    vertex.vertex_y <= v.y;
                    vertex.last_vertex <= v.last;
                end
                else
                    vertex.valid <= 1'b0;
            end
            result.ready <= $urandom_range(99) >= stall_pct;
        end
    end

    // monitor: predict on each accepted vertex, compare each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (vertex.valid && vertex.ready)
            begin
                predict_vertex('{vertex.vertex_x, vertex.vertex_y, vertex.last_vertex});
                vertices_sent++;
                vtx_taken = 1'b1;
            end
            if (result.valid && result.ready)
            begin
                rings_seen++;
                if (expected_rings.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result status %0d", result.status);
                end
                else
                begin
                    ring_res_t e;
                    e = expected_rings.pop_front();
                    if (result.double_area !== e.darea || result.centroid_x !== e.cx ||
                        result.centroid_y !== e.cy || result.was_clockwise !== e.cw ||
                        result.status !== e.st)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: exp a=%0d cx=%0d cy=%0d cw=%0b st=%0d got a=%0d cx=%0d cy=%0d cw=%0b st=%0d",
                                e.darea, e.cx, e.cy, e.cw, e.st,
                                result.double_area, result.centroid_x, result.centroid_y,
                                result.was_clockwise, result.status);
                    end
                end
            end
            if (cycles > 3000000)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL polygon_area_centroid_core");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1: return $signed(16'($urandom_range(200))) - 16'sd100;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    task automatic add_ring(int n);
        vertex_t v;
        for (int i = 0; i < n; i++)
        begin
            v.x = rand_coord();
            v.y = rand_coord();
            v.last = (i == n - 1);
            pending_vertices = {pending_vertices, v};
        end
    endtask

    task automatic add_vtx(int x, int y, logic last);
        vertex_t v;
        v.x = 16'(x);
        v.y = 16'(y);
        v.last = last;
        pending_vertices = {pending_vertices, v};
    endtask

    task automatic drain();
        while (pending_vertices.size() != 0 || vertex.valid || expected_rings.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_eps(logic [15:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        eps = value;
    endtask

    initial
    begin
        int n;
        errors = 0; mismatches = 0; rings_seen = 0; vertices_sent = 0; cycles = 0;
        idle_pct = 0; stall_pct = 0;
        vtx_taken = 1'b0;
        eps = '0;
        ring_clear();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        vertex.valid = 1'b0;
        vertex.vertex_x = '0;
        vertex.vertex_y = '0;
        vertex.last_vertex = 1'b0;
        result.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: ok ring both orders, short rings, degenerate, extremes, overlong
        add_vtx(0, 0, 0); add_vtx(100, 0, 0); add_vtx(0, 100, 1);
        add_vtx(0, 0, 0); add_vtx(0, 100, 0); add_vtx(100, 0, 1);
        add_vtx(5, 5, 1);
        add_vtx(1, 2, 0); add_vtx(3, 4, 1);
        add_vtx(0, 0, 0); add_vtx(1, 1, 0); add_vtx(2, 2, 1);
        add_vtx(-32768, -32768, 0); add_vtx(32767, -32768, 0);
        add_vtx(32767, 32767, 0); add_vtx(-32768, 32767, 1);
        add_vtx(32767, 32767, 0); add_vtx(32766, 32767, 0); add_vtx(32767, -32768, 1);
        drain();
        add_ring(65);
        add_ring(64);
        drain();

        // random phases over several thresholds, extremes included
        for (int ph = 0; ph < 4; ph++)
        begin
            write_eps(ph == 0 ? 16'd0 : ph == 1 ? 16'hffff : 16'($urandom()));
            idle_pct = ph == 1 ? 83 : ph == 3 ? 11 : 0;
            stall_pct = ph == 2 ? 83 : ph == 3 ? 11 : 0;
            while (pending_vertices.size() < 70)
            begin
                n = $urandom_range(19) == 0 ? $urandom_range(63, 66) : $urandom_range(1, 6);
                add_ring(n);
            end
            drain();
        end

        $display("sent %0d vertices, checked %0d ring results over four idle/stall phases",
            vertices_sent, rings_seen);
        if (errors == 0)
            $display("PASS polygon_area_centroid_core");
        else
            $display("FAIL polygon_area_centroid_core");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/pac_pkg.sv
rtl/pac_vertex_if.sv
rtl/pac_result_if.sv
rtl/pac_front.sv
rtl/pac_queue.sv
rtl/pac_div.sv
rtl/pac_back.sv
rtl/polygon_area_centroid_core.sv
verif/polygon_area_centroid_core_tb.sv
